[rtl/rtpc_pkg.sv]
// Shared types, constants and helpers for the RTP/RTCP payload classifier.
`default_nettype none

package rtpc_pkg;

    // Packet class codes
    localparam logic [1:0] CLASS_DISCARD = 2'd0;
    localparam logic [1:0] CLASS_RTP     = 2'd1;
    localparam logic [1:0] CLASS_RTCP    = 2'd2;
    localparam logic [1:0] CLASS_EVENT   = 2'd3;

    // Register indexes (paddr[2])
    localparam logic REG_EVENT_PT    = 1'b0;
    localparam logic REG_ACCEPT_MASK = 1'b1;

    // Register reset values
    localparam logic [6:0] EVENT_PT_RESET    = 7'd101;
    localparam logic [2:0] ACCEPT_MASK_RESET = 3'd7;

    // accept_mask bits
    localparam int unsigned MASK_BIT_RTP   = 0;
    localparam int unsigned MASK_BIT_RTCP  = 1;
    localparam int unsigned MASK_BIT_EVENT = 2;

    // Header matching
    localparam logic [7:0]  VERSION_MASK   = 8'hF0;
    localparam logic [7:0]  VOICE_NIBBLE   = 8'h80;
    localparam logic [7:0]  RTP_FIRST_BYTE = 8'h80;
    localparam logic [15:0] VOICE_MIN_LEN  = 16'd4;
    localparam logic [15:0] RTP_MIN_LEN    = 16'd12;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [17:0] OFFSET_MAX     = 18'h3FFFF;

    // RTCP subheader byte positions relative to the subheader start
    localparam logic [17:0] SUB_TYPE_POS   = 18'd1;
    localparam logic [17:0] SUB_LEN_HI_POS = 18'd2;
    localparam logic [17:0] SUB_LEN_LO_POS = 18'd3;

    localparam logic [7:0] RTCP_SR    = 8'd200;
    localparam logic [7:0] RTCP_APP   = 8'd204;
    localparam logic [7:0] RTCP_XR    = 8'd207;

    typedef struct packed {
        logic [6:0] event_pt;
        logic [2:0] accept_mask;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  packet_class;
        logic [15:0] payload_length;
    } t_result;

    function automatic logic rtcp_type_known(input logic [7:0] t);
        return ((t >= RTCP_SR) && (t <= RTCP_APP)) || (t == RTCP_XR);
    endfunction

endpackage

`default_nettype wire

[rtl/rtpc_core.sv]
// Per-packet state (count, header bytes, RTCP walk) and the class decision.
`default_nettype none

module rtpc_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    input  wire rtpc_pkg::t_cfg  i_cfg,
    output rtpc_pkg::t_result    o_result
);

    logic [15:0] r_byte_count, n_byte_count;
    logic [7:0]  r_first_byte, n_first_byte;
    logic [7:0]  r_second_byte, n_second_byte;
    logic [17:0] r_offset, n_offset;
    logic [7:0]  r_len_hi, n_len_hi;
    logic        r_walk_ok, n_walk_ok;

    logic [17:0] w_pos;
    logic [17:0] w_dist;
    logic [15:0] w_words;
    logic [18:0] w_next_sum;
    logic        w_voice, w_rtp, w_rtcp, w_evt;

    always_comb begin
        n_byte_count  = r_byte_count;
        n_first_byte  = r_first_byte;
        n_second_byte = r_second_byte;
        n_offset      = r_offset;
        n_len_hi      = r_len_hi;
        n_walk_ok     = r_walk_ok;

        w_pos      = {2'b00, r_byte_count};
        w_dist     = w_pos - r_offset;
        w_words    = {r_len_hi, i_byte};
        w_next_sum = {1'b0, r_offset} + {1'b0, w_words, 2'b00} + 19'd4;

        if (r_byte_count == rtpc_pkg::COUNT_MAX) begin
            n_walk_ok = 1'b0;
        end else begin
            if (r_byte_count == 16'd0) begin
                n_first_byte = i_byte;
            end
            if (r_byte_count == 16'd1) begin
                n_second_byte = i_byte;
            end
            if (w_pos >= r_offset) begin
                if (w_dist == rtpc_pkg::SUB_TYPE_POS) begin
                    if (!rtpc_pkg::rtcp_type_known(i_byte)) begin
                        n_walk_ok = 1'b0;
                    end
                end else if (w_dist == rtpc_pkg::SUB_LEN_HI_POS) begin
                    n_len_hi = i_byte;
                end else if (w_dist == rtpc_pkg::SUB_LEN_LO_POS) begin
                    n_offset = (w_next_sum > {1'b0, rtpc_pkg::OFFSET_MAX}) ?
                               rtpc_pkg::OFFSET_MAX : w_next_sum[17:0];
                end
            end
            n_byte_count = r_byte_count + 16'd1;
        end

        // decision on the post-update state
        w_voice = (n_byte_count > rtpc_pkg::VOICE_MIN_LEN) &&
                  ((n_first_byte & rtpc_pkg::VERSION_MASK) == rtpc_pkg::VOICE_NIBBLE);
        w_rtp   = w_voice && (n_byte_count > rtpc_pkg::RTP_MIN_LEN) &&
                  (n_first_byte == rtpc_pkg::RTP_FIRST_BYTE);
        w_rtcp  = w_rtp && n_walk_ok && (n_offset == {2'b00, n_byte_count});
        w_evt   = w_rtp && (n_second_byte[6:0] == i_cfg.event_pt);

        o_result.payload_length = n_byte_count;
        if (w_rtcp && i_cfg.accept_mask[rtpc_pkg::MASK_BIT_RTCP]) begin
            o_result.packet_class = rtpc_pkg::CLASS_RTCP;
        end else if (w_evt && i_cfg.accept_mask[rtpc_pkg::MASK_BIT_EVENT]) begin
            o_result.packet_class = rtpc_pkg::CLASS_EVENT;
        end else if (w_rtp && !w_rtcp && !w_evt &&
                     i_cfg.accept_mask[rtpc_pkg::MASK_BIT_RTP]) begin
            o_result.packet_class = rtpc_pkg::CLASS_RTP;
        end else begin
            o_result.packet_class = rtpc_pkg::CLASS_DISCARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_byte_count  <= '0;
            r_first_byte  <= '0;
            r_second_byte <= '0;
            r_offset      <= '0;
            r_len_hi      <= '0;
            r_walk_ok     <= 1'b1;
        end else if (i_step) begin
            r_byte_count  <= n_byte_count;
            r_first_byte  <= n_first_byte;
            r_second_byte <= n_second_byte;
            r_offset      <= n_offset;
            r_len_hi      <= n_len_hi;
            r_walk_ok     <= n_walk_ok;
        end
    end

endmodule

`default_nettype wire

[rtl/rtp_rtcp_payload_classifier_unit.sv]
// Top level of the RTP/RTCP payload classifier: stream ports, registers, stages.
//
//  channel   | dir | transaction                | payload
//  ----------+-----+----------------------------+------------------------------------
//  s_axis    | in  | one UDP payload byte       | tdata[7:0] data_byte, tlast last_byte
//  m_axis    | out | one class per payload      | tdata[15:0] length, tuser[1:0] class
//  apb       | in  | register write/read        | 0x0 event_payload_type, 0x4 accept_mask
//
// One byte per cycle sustained while m_axis takes its classes. The class decision is combinational on the
// held input byte; packet state and the result register load at the next edge,
// so a last byte passes the input stage and the result register before its class shows on m_axis.
// Reset (synchronous, active low) empties both stages, clears packet state
// and loads the register defaults (payload type 101, mask 7).
// s_axis_tready drops only while a last byte waits behind an untaken class.
`default_nettype none

module rtp_rtcp_payload_classifier_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    // stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] payload_length
    output logic [1:0]       m_axis_tuser,   // [1:0] packet_class
    // APB register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // config registers
    rtpc_pkg::t_cfg r_cfg;
    logic           w_cfg_wr;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // output stage
    logic              r_out_valid;
    rtpc_pkg::t_result r_out;
    rtpc_pkg::t_result w_result;

    logic w_in_acc;
    logic w_proc;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            rtpc_pkg::REG_EVENT_PT:    prdata = {25'd0, r_cfg.event_pt};
            rtpc_pkg::REG_ACCEPT_MASK: prdata = {29'd0, r_cfg.accept_mask};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.event_pt    <= rtpc_pkg::EVENT_PT_RESET;
            r_cfg.accept_mask <= rtpc_pkg::ACCEPT_MASK_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                rtpc_pkg::REG_EVENT_PT:    r_cfg.event_pt    <= pwdata[6:0];
                rtpc_pkg::REG_ACCEPT_MASK: r_cfg.accept_mask <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // the held byte moves on unless it would produce a class with nowhere to go
    assign w_proc        = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_proc;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    rtpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_proc),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.payload_length;
    assign m_axis_tuser  = r_out.packet_class;

endmodule

`default_nettype wire

[rtl/rtpc_checker.sv]
// Port-level checks for the classifier, bound to the top level.
`default_nettype none

module rtpc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // a stalled class holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // any accepted class implies an RTP-sized payload
    a_class_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != rtpc_pkg::CLASS_DISCARD) |->
            (m_axis_tdata > rtpc_pkg::RTP_MIN_LEN))
        else $error("class given to a short payload");

    // a compound RTCP walk ends on a word boundary
    a_rtcp_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == rtpc_pkg::CLASS_RTCP) |->
            (m_axis_tdata[1:0] == 2'b00))
        else $error("RTCP length not a multiple of four");

    // input only backs up behind a waiting class
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

bind rtp_rtcp_payload_classifier_unit rtpc_checker u_rtpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
